// ===== src/lrpf_pkg.sv =====
// Shared types, constants and helpers for the page-layout line rasterizer.
// Used by the divider and the top level.
package lrpf_pkg;

   localparam int COORD_W = 18;   // working coordinate width, signed
   localparam int ACC_W   = 34;   // 16.16 accumulator with headroom
   localparam int ADDR_W  = 10;   // frame store byte address
   localparam int DEPTH   = 1024; // frame store bytes
   localparam int IDX_W   = 18;   // unclipped byte index width
   localparam int DIV_W   = 12;   // divider operand magnitude width
   localparam int QUOT_W  = 28;   // dividend and quotient width

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ACC_W-1:0]   acc_type;

   typedef enum logic [1:0] {
      COLOUR_CLEAR  = 2'd0,
      COLOUR_SET    = 2'd1,
      COLOUR_INVERT = 2'd2,
      COLOUR_NONE   = 2'd3
   } colour_type;

   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Divider handshake
   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  num;
      logic [DIV_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

   // Sign-extend a 12-bit endpoint coordinate
   function automatic coord_type sext12(input logic [11:0] v);
      sext12 = {{(COORD_W-12){v[11]}}, v};
   endfunction

   // Apply the colour operation to one stored byte
   function automatic logic [7:0] apply_colour(input logic [7:0] data,
                                              input logic [7:0] mask,
                                              input colour_type colour);
      case (colour)
         COLOUR_CLEAR:  apply_colour = data & ~mask;
         COLOUR_SET:    apply_colour = data | mask;
         COLOUR_INVERT: apply_colour = data ^ mask;
         default:       apply_colour = data;
      endcase
   endfunction

endpackage

// ===== src/lrpf_req_if.sv =====
// Command channel: valid/ready plus one command beat.
// Depends on nothing but plain types.
interface lrpf_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [11:0] x_start;
   logic signed [11:0] y_start;
   logic signed [11:0] x_end;
   logic signed [11:0] y_end;
   logic [9:0]         byte_address;

   modport source (output valid, cmd, x_start, y_start, x_end, y_end, byte_address,
                   input ready);
   modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, byte_address,
                   output ready);
endinterface

// ===== src/lrpf_rsp_if.sv =====
// Read response channel: valid/ready plus one framebuffer byte.
// Depends on nothing but plain types.
interface lrpf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink   (input valid, read_data, output ready);
endinterface

// ===== src/lrpf_csr_if.sv =====
// Configuration write channel: valid/ready plus the draw colour.
// Depends on nothing but plain types.
interface lrpf_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] draw_colour;

   modport source (output valid, draw_colour, input ready);
   modport sink   (input valid, draw_colour, output ready);
endinterface

// ===== src/line_rasterizer_page_framebuffer_core.sv =====
// Line rasterizer over a 1-bit-per-pixel page framebuffer; top level.
// Depends on lrpf_pkg, the three channel interfaces, lrpf_ram and lrpf_divider.
//
// After reset the block sweeps the 1024-byte frame store to zero, one byte per
// cycle, and takes no command until that is done; colour writes are taken at
// any time. One command is handled at a time. A read passes through ST_RD_ADDR
// and ST_RD_WAIT, where it waits while an earlier response is not yet taken,
// before its byte is registered for the response beat. A draw spends a plot
// and a write state per touched byte, since each one is a read-modify-write
// through the single frame store: a vertical line touches one byte per page, a
// horizontal or sloped line one byte per pixel. Sloped lines first go through
// the bit-serial divider that forms the 16.16 step. Pixels off screen take the
// plot state only, with no write.
module line_rasterizer_page_framebuffer_core #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic       clock,
   input  logic       reset,
   lrpf_req_if.sink   req_bus,
   lrpf_rsp_if.source rsp_bus,
   lrpf_csr_if.sink   csr_bus
);
   localparam int CW = lrpf_pkg::COORD_W;
   localparam int AW = lrpf_pkg::ACC_W;
   localparam int XW = lrpf_pkg::IDX_W;
   localparam int RW = lrpf_pkg::ADDR_W;
   localparam lrpf_pkg::coord_type W_C  = CW'(SCREEN_WIDTH);
   localparam lrpf_pkg::coord_type H_C  = CW'(SCREEN_HEIGHT);
   localparam lrpf_pkg::coord_type WM_C = CW'(SCREEN_WIDTH - 1);
   localparam lrpf_pkg::coord_type HM_C = CW'(SCREEN_HEIGHT - 1);

   typedef enum logic [7:0] {
      ST_CLEAR   = 8'b0000_0001,
      ST_IDLE    = 8'b0000_0010,
      ST_SETUP   = 8'b0000_0100,
      ST_DIVIDE  = 8'b0000_1000,
      ST_PLOT    = 8'b0001_0000,
      ST_WRITE   = 8'b0010_0000,
      ST_RD_ADDR = 8'b0100_0000,
      ST_RD_WAIT = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      MODE_VERT  = 2'd0,
      MODE_HORZ  = 2'd1,
      MODE_SLOPE = 2'd2
   } mode_type;

   state_type            state_ff, state_in;
   lrpf_pkg::colour_type colour_ff, colour_in;
   mode_type             mode_ff, mode_in;
   logic                 steep_ff, steep_in;
   logic                 dir_ff, dir_in;
   logic                 neg_ff, neg_in;
   logic [11:0]          xs_ff, ys_ff, xe_ff, ye_ff;
   logic [RW-1:0]        baddr_ff;
   lrpf_pkg::coord_type  c_ff, c_in;
   lrpf_pkg::coord_type  fix_ff, fix_in;
   lrpf_pkg::coord_type  last_ff, last_in;
   logic [11:0]          cnt_ff, cnt_in;
   lrpf_pkg::acc_type    acc_ff, acc_in;
   lrpf_pkg::acc_type    step_ff, step_in;
   logic [RW-1:0]        wr_addr_ff;
   logic [7:0]           wr_mask_ff;
   logic                 fin_ff, fin_in;
   logic [RW-1:0]        clr_cnt_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_data_ff;

   lrpf_pkg::div_req_type div_req;
   lrpf_pkg::div_rsp_type div_rsp;

   logic          ram_wr_en;
   logic [RW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic [RW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   // Setup decode
   lrpf_pkg::coord_type xs, ys, xe, ye, dx, dy, adx, ady, sl, ll;
   lrpf_pkg::coord_type lo_y, hi_y, lo_x, hi_x, fix_s;
   logic                steep, ok_v, ok_h;

   // Per-pixel address
   lrpf_pkg::coord_type px, py, c_or7, c_next;
   logic [2:0]          hi_bit;
   logic [7:0]          mask;
   logic                is_last, in_screen, hit;
   logic [XW-1:0]       idx;
   lrpf_pkg::acc_type   quot_s;
   logic                load_rsp, accept;

   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign colour_in = (csr_bus.valid) ? lrpf_pkg::colour_type'(csr_bus.draw_colour)
                                      : colour_ff;

   // Line classification and clipping decisions
   always_comb begin
      xs    = lrpf_pkg::sext12(xs_ff);
      ys    = lrpf_pkg::sext12(ys_ff);
      xe    = lrpf_pkg::sext12(xe_ff);
      ye    = lrpf_pkg::sext12(ye_ff);
      dx    = xe - xs;
      dy    = ye - ys;
      adx   = dx[CW-1] ? -dx : dx;
      ady   = dy[CW-1] ? -dy : dy;
      steep = ady > adx;
      sl    = steep ? dx : dy;
      ll    = steep ? dy : dx;
      fix_s = steep ? xs : ys;
      lo_y  = (ys < ye) ? ys : ye;
      hi_y  = (ys < ye) ? ye : ys;
      lo_x  = (xs < xe) ? xs : xe;
      hi_x  = (xs < xe) ? xe : xs;
      ok_v  = (xs >= 0) && (xs < W_C) && (lo_y >= 0) && (lo_y < H_C);
      ok_h  = (ys >= 0) && (ys < H_C) && (lo_x < W_C) && (hi_x >= 0);
   end

   // Pixel or byte at the current position
   always_comb begin
      c_or7  = {c_ff[CW-1:3], 3'b111};
      hi_bit = (last_ff < c_or7) ? last_ff[2:0] : 3'd7;
      px      = c_ff;
      py      = fix_ff;
      mask    = 8'h01 << py[2:0];
      is_last = (c_ff >= last_ff);
      c_next  = c_ff + CW'(1);
      unique case (mode_ff)
         MODE_VERT: begin
            px      = fix_ff;
            py      = c_ff;
            mask    = (8'hFF << c_ff[2:0]) & (8'hFF >> (3'd7 - hi_bit));
            is_last = (c_or7 >= last_ff);
            c_next  = c_or7 + CW'(1);
         end
         MODE_SLOPE: begin
            px      = steep_ff ? acc_ff[AW-1:16] : c_ff;
            py      = steep_ff ? c_ff : acc_ff[AW-1:16];
            mask    = 8'h01 << py[2:0];
            is_last = (cnt_ff == 12'd0);
            c_next  = dir_ff ? c_ff + CW'(1) : c_ff - CW'(1);
         end
         default: begin
         end
      endcase
      in_screen = (px >= 0) && (px < W_C) && (py >= 0) && (py < H_C);
      idx = XW'(px[10:0]) + XW'(py[12:3]) * XW'(SCREEN_WIDTH);
      hit = in_screen && (idx[XW-1:RW] == '0);
   end

   assign quot_s = AW'(div_rsp.quot);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      steep_in      = steep_ff;
      dir_in        = dir_ff;
      neg_in        = neg_ff;
      c_in          = c_ff;
      fix_in        = fix_ff;
      last_in       = last_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      step_in       = step_ff;
      fin_in        = fin_ff;
      div_req.start = 1'b0;
      div_req.num   = adx[11:0];
      div_req.den   = adx[11:0];
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wr_addr_ff;
      ram_wr_data   = lrpf_pkg::apply_colour(ram_rd_data, wr_mask_ff, colour_ff);
      ram_rd_addr   = idx[RW-1:0];
      load_rsp      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = 8'h00;
            if (clr_cnt_ff == RW'(lrpf_pkg::DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_bus.cmd == lrpf_pkg::CMD_READ) ? ST_RD_ADDR : ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_IDLE;
            if (xs == xe) begin
               mode_in = MODE_VERT;
               c_in    = lo_y;
               fix_in  = xs;
               last_in = (hi_y > HM_C) ? HM_C : hi_y;
               if (ok_v && colour_ff != lrpf_pkg::COLOUR_NONE) begin
                  state_in = ST_PLOT;
               end
            end else if (ys == ye) begin
               mode_in = MODE_HORZ;
               c_in    = (lo_x < 0) ? '0 : lo_x;
               fix_in  = ys;
               last_in = (hi_x > WM_C) ? WM_C : hi_x;
               if (ok_h && colour_ff != lrpf_pkg::COLOUR_NONE) begin
                  state_in = ST_PLOT;
               end
            end else begin
               mode_in       = MODE_SLOPE;
               steep_in      = steep;
               dir_in        = !ll[CW-1];
               neg_in        = sl[CW-1] ^ ll[CW-1];
               c_in          = steep ? ys : xs;
               acc_in        = {fix_s, 16'h8000};
               cnt_in        = steep ? ady[11:0] : adx[11:0];
               div_req.num   = steep ? adx[11:0] : ady[11:0];
               div_req.den   = steep ? ady[11:0] : adx[11:0];
               if (colour_ff != lrpf_pkg::COLOUR_NONE) begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               // step sign: quotient sign, flipped when walking backwards
               step_in  = (neg_ff ^ !dir_ff) ? -quot_s : quot_s;
               state_in = ST_PLOT;
            end
         end
         ST_PLOT: begin
            c_in   = c_next;
            acc_in = acc_ff + step_ff;
            cnt_in = cnt_ff - 12'd1;
            fin_in = is_last;
            if (hit) begin
               state_in = ST_WRITE;
            end else if (is_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            ram_wr_en = 1'b1;
            state_in  = fin_ff ? ST_IDLE : ST_PLOT;
         end
         ST_RD_ADDR: begin
            ram_rd_addr = baddr_ff;
            state_in    = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            ram_rd_addr = baddr_ff;
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         colour_ff    <= lrpf_pkg::COLOUR_SET;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_VERT;
         fin_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         colour_ff    <= colour_in;
         clr_cnt_ff   <= clr_cnt_ff + RW'(1);
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         fin_ff       <= fin_in;
      end
      if (accept) begin
         xs_ff    <= req_bus.x_start;
         ys_ff    <= req_bus.y_start;
         xe_ff    <= req_bus.x_end;
         ye_ff    <= req_bus.y_end;
         baddr_ff <= req_bus.byte_address;
      end
      if (state_ff == ST_PLOT) begin
         wr_addr_ff <= idx[RW-1:0];
         wr_mask_ff <= mask;
      end
      if (load_rsp) begin
         rsp_data_ff <= ram_rd_data;
      end
      steep_ff <= steep_in;
      dir_ff   <= dir_in;
      neg_ff   <= neg_in;
      c_ff     <= c_in;
      fix_ff   <= fix_in;
      last_ff  <= last_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      step_ff  <= step_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_data_ff;

   lrpf_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   lrpf_ram #(
      .WIDTH (8),
      .DEPTH (lrpf_pkg::DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );
endmodule

// ===== src/lrpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/lrpf_divider.sv =====
// Restoring divider, one quotient bit per cycle: (num << 16) / den, unsigned.
// Depends on lrpf_pkg.
module lrpf_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  lrpf_pkg::div_req_type req,
   output lrpf_pkg::div_rsp_type rsp
);
   localparam int CNT_W = $clog2(lrpf_pkg::QUOT_W + 1);

   logic [lrpf_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [lrpf_pkg::QUOT_W-1:0] quo_ff, quo_in;
   logic [lrpf_pkg::DIV_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [lrpf_pkg::DIV_W:0]    shifted;
   logic [lrpf_pkg::DIV_W+1:0]  diff;

   // One trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[lrpf_pkg::QUOT_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = {req.num, 16'h0000};
         den_in  = req.den;
         cnt_in  = CNT_W'(lrpf_pkg::QUOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[lrpf_pkg::DIV_W+1]) begin
            rem_in = diff[lrpf_pkg::DIV_W-1:0];
            quo_in = {quo_ff[lrpf_pkg::QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[lrpf_pkg::DIV_W-1:0];
            quo_in = {quo_ff[lrpf_pkg::QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;
endmodule
